FILE: sv/pcx_rle_palette_decoder_assert.svh
// Assertion macros shared by the PCX run-length palette decoder.
// No dependencies; taken in by the top level with an include.
`ifndef PCX_RLE_PALETTE_DECODER_ASSERT_SVH
`define PCX_RLE_PALETTE_DECODER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define PCX_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("pcx decoder: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define PCX_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("pcx decoder: next-cycle check failed");

`endif

FILE: sv/pcx_pkg.sv
// Shared types and constants of the PCX run-length palette decoder.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package pcx_pkg;

    // Geometry limits and palette size.
    localparam int unsigned MAX_DIMENSION = 4096;
    localparam int unsigned PALETTE_DEPTH = 256;
    localparam int unsigned PAL_ADDR_W    = $clog2(PALETTE_DEPTH);

    // Configuration port layout.
    localparam int unsigned CFG_ADDR_W = 4;
    localparam logic [1:0]  REG_WIDTH  = 2'd0;
    localparam logic [1:0]  REG_HEIGHT = 2'd1;
    localparam logic [1:0]  REG_BPL    = 2'd2;

    // Run-length marker and count mask.
    localparam logic [7:0] RUN_MARK = 8'hC0;
    localparam logic [7:0] RUN_MASK = 8'h3F;

    typedef enum logic [1:0] {
        ACT_LOAD  = 2'd0,
        ACT_DATA  = 2'd1,
        ACT_START = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        KIND_PIXEL = 2'd0,
        KIND_DONE  = 2'd1,
        KIND_TRUNC = 2'd2,
        KIND_GEOM  = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_RUN,
        ST_FLAG,
        ST_FLUSH
    } seq_state_t;

    // One result beat without its last flag.
    typedef struct packed {
        kind_t       kind;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [11:0] column;
        logic [11:0] row;
    } res_t;

    // Sequencer requests to the result stage.
    typedef struct packed {
        logic gen;
        logic flush;
    } emit_ctl_t;

endpackage

FILE: sv/pcx_rle_palette_decoder.sv
// PCX 8-bit run-length decoder with palette lookup. Data bytes are accepted one at a
// time: a palette load or a start of image is taken in the idle state, a count byte
// passes the check and flush states, a literal or a run also the run state, one
// position per cycle through the single position step unit, stretched when the result
// channel stalls; a completion, truncation or geometry beat adds the flag state.
// Top level: configuration registers on the APB-style port, sequencer, palette, result stage.
// Depends on pcx_pkg, pcx_pal, pcx_seq, pcx_outq and the assertion macro header.
`timescale 1ns / 1ps

`include "pcx_rle_palette_decoder_assert.svh"

module pcx_rle_palette_decoder (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Configuration port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [pcx_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    // Input channel
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [1:0]                     s_action,
    input  logic [7:0]                     s_data_byte,
    input  logic [7:0]                     s_palette_index,
    input  logic [23:0]                    s_palette_color,
    input  logic                           s_final_byte,
    // Result channel
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [1:0]                     m_kind,
    output logic [7:0]                     m_red,
    output logic [7:0]                     m_green,
    output logic [7:0]                     m_blue,
    output logic [11:0]                    m_column,
    output logic [11:0]                    m_row,
    output logic                           m_last
);
    import pcx_pkg::*;

    logic [12:0] width_reg;
    logic [12:0] height_reg;
    logic [15:0] bpl_reg;

    logic        cfg_write;
    logic        in_accept;
    logic        pal_wr_en;
    logic        pal_rd_en;
    logic [PAL_ADDR_W-1:0] pal_rd_addr;
    logic [23:0] pal_rd_data;
    logic        hold_ready;
    emit_ctl_t   emit_ctl;
    res_t        emit_res;
    res_t        m_res;

    // Configuration registers.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= 13'd1;
            height_reg <= 13'd1;
            bpl_reg    <= 16'd1;
        end else if (cfg_write) begin
            unique case (paddr[3:2])
                REG_WIDTH:  width_reg  <= pwdata[12:0];
                REG_HEIGHT: height_reg <= pwdata[12:0];
                REG_BPL:    bpl_reg    <= pwdata[15:0];
                default: begin
                end
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        unique case (paddr[3:2])
            REG_WIDTH:  prdata = {19'd0, width_reg};
            REG_HEIGHT: prdata = {19'd0, height_reg};
            REG_BPL:    prdata = {16'd0, bpl_reg};
            default:    prdata = 32'd0;
        endcase
    end

    // Input beat acceptance and palette loads.
    assign in_accept = s_valid && s_ready;
    assign pal_wr_en = in_accept && (s_action == ACT_LOAD);

    pcx_pal u_pal (
        .aclk    (aclk),
        .wr_en   (pal_wr_en),
        .wr_addr (s_palette_index),
        .wr_data (s_palette_color),
        .rd_en   (pal_rd_en),
        .rd_addr (pal_rd_addr),
        .rd_data (pal_rd_data)
    );

    pcx_seq u_seq (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_accept      (in_accept),
        .in_action      (s_action),
        .in_data_byte   (s_data_byte),
        .in_final_byte  (s_final_byte),
        .image_width    (width_reg),
        .image_height   (height_reg),
        .bytes_per_line (bpl_reg),
        .pal_rd_data    (pal_rd_data),
        .hold_ready     (hold_ready),
        .in_ready       (s_ready),
        .pal_rd_en      (pal_rd_en),
        .pal_rd_addr    (pal_rd_addr),
        .emit_ctl       (emit_ctl),
        .emit_res       (emit_res)
    );

    pcx_outq u_outq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .emit_ctl   (emit_ctl),
        .emit_res   (emit_res),
        .hold_ready (hold_ready),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_res      (m_res),
        .m_last     (m_last)
    );

    assign m_kind   = m_res.kind;
    assign m_red    = m_res.red;
    assign m_green  = m_res.green;
    assign m_blue   = m_res.blue;
    assign m_column = m_res.column;
    assign m_row    = m_res.row;

    // Status beats carry no colour or position and always close their item.
    `PCX_ASSERT_IMP(a_flag_zero, aclk, aresetn, m_valid && (m_kind != KIND_PIXEL), m_red == 8'd0 && m_green == 8'd0 && m_blue == 8'd0 && m_column == 12'd0 && m_row == 12'd0)
    `PCX_ASSERT_IMP(a_flag_last, aclk, aresetn, m_valid && (m_kind != KIND_PIXEL), m_last)
    // Palette loads and image starts complete in the cycle they are taken.
    `PCX_ASSERT_NEXT(a_quick_actions, aclk, aresetn, in_accept && (s_action == ACT_LOAD || s_action == ACT_START), s_ready)

endmodule

FILE: sv/pcx_pal.sv
// Palette memory: one write port, one registered read port.
// Depends on pcx_pkg for the palette depth.
`timescale 1ns / 1ps

module pcx_pal (
    input  logic                           aclk,
    input  logic                           wr_en,
    input  logic [pcx_pkg::PAL_ADDR_W-1:0] wr_addr,
    input  logic [23:0]                    wr_data,
    input  logic                           rd_en,
    input  logic [pcx_pkg::PAL_ADDR_W-1:0] rd_addr,
    output logic [23:0]                    rd_data
);
    import pcx_pkg::*;

    logic [23:0] mem_reg [PALETTE_DEPTH];
    logic [23:0] rd_data_reg;

    // Entries are undefined until loaded, so the array has no reset.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: sv/pcx_seq.sv
// Decode sequencer: image state, run expansion and the position step unit.
// Depends on pcx_pkg; drives the palette read port and the result stage.
`timescale 1ns / 1ps

module pcx_seq (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           in_accept,
    input  logic [1:0]                     in_action,
    input  logic [7:0]                     in_data_byte,
    input  logic                           in_final_byte,
    input  logic [12:0]                    image_width,
    input  logic [12:0]                    image_height,
    input  logic [15:0]                    bytes_per_line,
    input  logic [23:0]                    pal_rd_data,
    input  logic                           hold_ready,
    output logic                           in_ready,
    output logic                           pal_rd_en,
    output logic [pcx_pkg::PAL_ADDR_W-1:0] pal_rd_addr,
    output pcx_pkg::emit_ctl_t             emit_ctl,
    output pcx_pkg::res_t                  emit_res
);
    import pcx_pkg::*;

    seq_state_t  state_reg, state_next;
    logic        pending_reg, pending_next;
    logic [5:0]  run_reg, run_next;
    logic [15:0] pos_reg, pos_next;
    logic [12:0] line_reg, line_next;
    logic        finished_reg, finished_next;
    logic [7:0]  byte_reg, byte_next;
    logic        fin_reg, fin_next;
    logic [5:0]  cnt_reg, cnt_next;
    kind_t       flag_reg, flag_next;

    logic        geom_bad;
    logic        visible;
    logic [15:0] pos_inc;
    logic [12:0] line_inc;
    logic        line_end;
    logic [5:0]  start_count;
    seq_state_t  tail_state;

    // Step unit: one position advance and its line-end compare per unstalled cycle.
    assign pos_inc  = pos_reg + 16'd1;
    assign line_inc = line_reg + 13'd1;
    assign line_end = (pos_inc >= bytes_per_line) || (pos_inc == 16'd0);
    assign visible  = pos_reg < {3'd0, image_width};

    // Geometry is checked against the registers on every data byte of an open image.
    assign geom_bad = (image_width == 13'd0) || ({19'd0, image_width} > MAX_DIMENSION) ||
                      (image_height == 13'd0) || ({19'd0, image_height} > MAX_DIMENSION) ||
                      (bytes_per_line < {3'd0, image_width});

    assign start_count = pending_reg ? run_reg : 6'd1;
    assign tail_state  = fin_reg ? ST_FLAG : ST_FLUSH;

    assign pal_rd_addr = byte_reg;

    // Next state and outputs of the sequencer.
    always_comb begin
        state_next    = state_reg;
        pending_next  = pending_reg;
        run_next      = run_reg;
        pos_next      = pos_reg;
        line_next     = line_reg;
        finished_next = finished_reg;
        byte_next     = byte_reg;
        fin_next      = fin_reg;
        cnt_next      = cnt_reg;
        flag_next     = flag_reg;
        in_ready      = 1'b0;
        pal_rd_en     = 1'b0;
        emit_ctl      = '0;
        emit_res      = '0;

        unique case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_accept) begin
                    unique case (in_action)
                        ACT_START: begin
                            pending_next  = 1'b0;
                            run_next      = 6'd0;
                            pos_next      = 16'd0;
                            line_next     = 13'd0;
                            finished_next = 1'b0;
                        end
                        ACT_DATA: begin
                            if (!finished_reg) begin
                                byte_next  = in_data_byte;
                                fin_next   = in_final_byte;
                                state_next = ST_CHECK;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            ST_CHECK: begin
                if (geom_bad) begin
                    flag_next  = KIND_GEOM;
                    state_next = ST_FLAG;
                end else if (line_reg >= image_height) begin
                    flag_next  = KIND_DONE;
                    state_next = ST_FLAG;
                end else if (!pending_reg && ((byte_reg & RUN_MARK) == RUN_MARK)) begin
                    // Count byte: remember the run for the next byte.
                    pending_next = 1'b1;
                    run_next     = byte_reg[5:0];
                    flag_next    = KIND_TRUNC;
                    state_next   = tail_state;
                end else begin
                    pending_next = 1'b0;
                    run_next     = 6'd0;
                    if (start_count == 6'd0) begin
                        flag_next  = KIND_TRUNC;
                        state_next = tail_state;
                    end else begin
                        pal_rd_en  = 1'b1;
                        cnt_next   = start_count;
                        state_next = ST_RUN;
                    end
                end
            end

            ST_RUN: begin
                emit_res.kind   = KIND_PIXEL;
                emit_res.red    = pal_rd_data[23:16];
                emit_res.green  = pal_rd_data[15:8];
                emit_res.blue   = pal_rd_data[7:0];
                emit_res.column = pos_reg[11:0];
                emit_res.row    = line_reg[11:0];
                // Padding positions advance without waiting for the result stage.
                if (!visible || hold_ready) begin
                    emit_ctl.gen = visible;
                    if (line_end) begin
                        pos_next  = 16'd0;
                        line_next = line_inc;
                        if (line_inc >= image_height) begin
                            flag_next  = KIND_DONE;
                            state_next = ST_FLAG;
                        end else begin
                            flag_next  = KIND_TRUNC;
                            state_next = tail_state;
                        end
                    end else begin
                        pos_next = pos_inc;
                        if (cnt_reg == 6'd1) begin
                            flag_next  = KIND_TRUNC;
                            state_next = tail_state;
                        end else begin
                            cnt_next = cnt_reg - 6'd1;
                        end
                    end
                end
            end

            ST_FLAG: begin
                emit_res.kind = flag_reg;
                if (hold_ready) begin
                    emit_ctl.gen  = 1'b1;
                    finished_next = 1'b1;
                    state_next    = ST_FLUSH;
                end
            end

            ST_FLUSH: begin
                emit_ctl.flush = 1'b1;
                if (hold_ready) begin
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            pending_reg  <= 1'b0;
            run_reg      <= 6'd0;
            pos_reg      <= 16'd0;
            line_reg     <= 13'd0;
            finished_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            pending_reg  <= pending_next;
            run_reg      <= run_next;
            pos_reg      <= pos_next;
            line_reg     <= line_next;
            finished_reg <= finished_next;
        end
    end

    // Working copies of the current byte.
    always_ff @(posedge aclk) begin
        byte_reg <= byte_next;
        fin_reg  <= fin_next;
        cnt_reg  <= cnt_next;
        flag_reg <= flag_next;
    end

endmodule

FILE: sv/pcx_outq.sv
// Result stage: a hold register that learns the last flag, then the output register.
// Depends on pcx_pkg; fed by the decode sequencer.
`timescale 1ns / 1ps

module pcx_outq (
    input  logic               aclk,
    input  logic               aresetn,
    input  pcx_pkg::emit_ctl_t emit_ctl,
    input  pcx_pkg::res_t      emit_res,
    output logic               hold_ready,
    output logic               m_valid,
    input  logic               m_ready,
    output pcx_pkg::res_t      m_res,
    output logic               m_last
);
    import pcx_pkg::*;

    logic hold_valid_reg;
    res_t hold_res_reg;
    logic out_valid_reg;
    res_t out_res_reg;
    logic out_last_reg;

    logic out_free;
    logic push;

    // A held beat moves on once its successor, or the end of the item, is known.
    assign out_free   = !out_valid_reg || m_ready;
    assign hold_ready = !hold_valid_reg || out_free;
    assign push       = hold_valid_reg && out_free && (emit_ctl.gen || emit_ctl.flush);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (emit_ctl.gen && hold_ready) begin
                hold_valid_reg <= 1'b1;
            end else if (emit_ctl.flush && hold_ready) begin
                hold_valid_reg <= 1'b0;
            end
            if (push) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (emit_ctl.gen && hold_ready) begin
            hold_res_reg <= emit_res;
        end
        if (push) begin
            out_res_reg  <= hold_res_reg;
            out_last_reg <= emit_ctl.flush;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_res   = out_res_reg;
    assign m_last  = out_last_reg;

endmodule

FILE: dv/tb.sv
// Self-checking testbench for pcx_rle_palette_decoder: palette loads, run-length streams,
// geometry errors and register changes, checked beat by beat against an in-bench predictor.
// Depends on pcx_pkg and the pcx_rle_palette_decoder top level.
`timescale 1ns / 1ps

module tb;
    import pcx_pkg::*;

    localparam logic [1:0]  ACT_UNUSED   = 2'd3;
    localparam int unsigned TAIL_CYCLES  = 80;    // longest run over padding plus margin
    localparam int unsigned QUIET_LIMIT  = 3000;  // cycles without any handshake or register access
    localparam int unsigned MAX_REPORTS  = 50;
    localparam int unsigned USED_ENTRIES = 48;    // palette entries that the stimulus reads

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  red, green, blue;
        logic [11:0] column, row;
        logic        last;
    } out_beat_t;

    // Clock, reset and block inputs, all known from time zero.
    logic        aclk;
    logic        aresetn = 1'b0;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_action = 2'd0;
    logic [7:0]  s_data_byte = 8'd0;
    logic [7:0]  s_palette_index = 8'd0;
    logic [23:0] s_palette_color = 24'd0;
    logic        s_final_byte = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_kind;
    logic [7:0]  m_red, m_green, m_blue;
    logic [11:0] m_column, m_row;
    logic        m_last;

    // Predictor state: palette copy, decoder position and current register values.
    logic [23:0] pal_shadow [PALETTE_DEPTH];
    logic        run_armed;
    logic [5:0]  run_count;
    logic [15:0] col_pos;
    logic [12:0] line_idx;
    logic        img_closed;
    logic [12:0] cfg_w = 13'd1, cfg_h = 13'd1;
    logic [15:0] cfg_bpl = 16'd1;

    out_beat_t   decoded_q[$];
    out_beat_t   held;
    logic        have_held;
    out_beat_t   want;

    int unsigned fault_count  = 0;
    int unsigned beats_sent   = 0;
    int unsigned results_seen = 0;
    int unsigned images_run   = 0;
    int unsigned reg_writes   = 0;
    int unsigned quiet_cycles = 0;
    int unsigned stall_left   = 0;
    bit          idle_on      = 1'b1;

    pcx_rle_palette_decoder DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_action        (s_action),
        .s_data_byte     (s_data_byte),
        .s_palette_index (s_palette_index),
        .s_palette_color (s_palette_color),
        .s_final_byte    (s_final_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_kind          (m_kind),
        .m_red           (m_red),
        .m_green         (m_green),
        .m_blue          (m_blue),
        .m_column        (m_column),
        .m_row           (m_row),
        .m_last          (m_last)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Idle length for either side: mostly none, sometimes short, now and then long.
    function automatic int unsigned pick_gap(input int unsigned pct);
        if (!idle_on || $urandom_range(0, 99) >= pct) return 0;
        return ($urandom_range(0, 9) == 0) ? $urandom_range(12, 40) : $urandom_range(1, 3);
    endfunction

    // Results of one input beat are held back by one so that the last one can be flagged.
    function automatic void note_result(input kind_t k, input logic [23:0] rgb,
                                        input logic [11:0] x, input logic [11:0] y);
        if (have_held) decoded_q.push_back(held);
        held = '{kind: k, red: rgb[23:16], green: rgb[15:8], blue: rgb[7:0],
                 column: x, row: y, last: 1'b0};
        have_held = 1'b1;
    endfunction

    function automatic void clear_image();
        run_armed  = 1'b0;
        run_count  = '0;
        col_pos    = '0;
        line_idx   = '0;
        img_closed = 1'b0;
    endfunction

    // Expands one data byte into pixels, line ends and end-of-image, truncation and geometry reports.
    function automatic void expand_data_byte(input logic [7:0] b, input logic fin);
        int unsigned reps;
        logic [23:0] rgb;
        if (cfg_w == 0 || cfg_w > MAX_DIMENSION || cfg_h == 0 || cfg_h > MAX_DIMENSION ||
            cfg_bpl < cfg_w) begin
            note_result(KIND_GEOM, '0, '0, '0);
            img_closed = 1'b1;
            return;
        end
        if (line_idx >= cfg_h) begin
            note_result(KIND_DONE, '0, '0, '0);
            img_closed = 1'b1;
            return;
        end
        if (!run_armed && (b & RUN_MARK) == RUN_MARK) begin
            run_armed = 1'b1;
            run_count = 6'(b & RUN_MASK);
        end else begin
            reps      = run_armed ? run_count : 1;
            run_armed = 1'b0;
            run_count = '0;
            rgb       = pal_shadow[b];
            for (int i = 0; i < reps; i++) begin
                if (col_pos < cfg_w) note_result(KIND_PIXEL, rgb, col_pos[11:0], line_idx[11:0]);
                col_pos = col_pos + 16'd1;
                // A run never carries over into the next line.
                if (col_pos >= cfg_bpl || col_pos == 0) begin
                    col_pos  = '0;
                    line_idx = line_idx + 13'd1;
                    if (line_idx >= cfg_h) begin
                        note_result(KIND_DONE, '0, '0, '0);
                        img_closed = 1'b1;
                    end
                    break;
                end
            end
        end
        if (!img_closed && fin) begin
            note_result(KIND_TRUNC, '0, '0, '0);
            img_closed = 1'b1;
        end
    endfunction

    function automatic void decode_beat(input logic [1:0] act, input logic [7:0] b,
                                        input logic [7:0] idx, input logic [23:0] colour,
                                        input logic fin);
        have_held = 1'b0;
        case (act)
            ACT_LOAD:  pal_shadow[idx] = colour;
            ACT_START: clear_image();
            ACT_DATA:  if (!img_closed) expand_data_byte(b, fin);
            default: ;
        endcase
        if (have_held) begin
            held.last = 1'b1;
            decoded_q.push_back(held);
        end
    endfunction

    // Sends one input beat after a random gap and predicts its results once accepted.
    task automatic send_beat(input logic [1:0] act, input logic [7:0] b, input logic [7:0] idx,
                             input logic [23:0] colour, input logic fin);
        int unsigned gap;
        gap = pick_gap(35);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_action        <= act;
        s_data_byte     <= b;
        s_palette_index <= idx;
        s_palette_color <= colour;
        s_final_byte    <= fin;
        do @(posedge aclk); while (!s_ready);
        if (!(act == ACT_UNUSED || (act == ACT_DATA && img_closed))) beats_sent++;
        decode_beat(act, b, idx, colour, fin);
    endtask

    task automatic send_data(input logic [7:0] b, input logic fin);
        send_beat(ACT_DATA, b, 8'($urandom), 24'($urandom), fin);
    endtask

    task automatic send_run(input logic [5:0] count, input logic [7:0] index);
        send_data(RUN_MARK | {2'b00, count}, 1'b0);
        send_data(index, 1'b0);
    endtask

    task automatic start_image();
        images_run++;
        send_beat(ACT_START, 8'($urandom), 8'($urandom), 24'($urandom), 1'($urandom));
    endtask

    // Holds the sender off until every predicted result has been seen.
    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (decoded_q.size() != 0);
    endtask

    task automatic write_reg(input logic [1:0] sel, input logic [15:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= {16'd0, value};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (sel)
            REG_WIDTH:  cfg_w = value[12:0];
            REG_HEIGHT: cfg_h = value[12:0];
            REG_BPL:    cfg_bpl = value;
            default: ;
        endcase
        reg_writes++;
        @(posedge aclk);
    endtask

    // Registers change only once the block has gone quiet, padding runs included.
    task automatic set_geometry(input int unsigned w, input int unsigned h,
                                input int unsigned bpl);
        drain();
        repeat (TAIL_CYCLES) @(posedge aclk);
        write_reg(REG_WIDTH, 16'(w));
        write_reg(REG_HEIGHT, 16'(h));
        write_reg(REG_BPL, 16'(bpl));
    endtask

    // Pixel indices the stimulus reads: two blocks of literals and a block only runs can use.
    function automatic logic [7:0] used_index(input int unsigned k);
        if (k < 16) return 8'(k);
        if (k < 32) return 8'(8'hB0 + k - 16);
        return 8'(8'hF0 + k - 32);
    endfunction

    function automatic logic [7:0] rand_literal();
        return used_index($urandom_range(0, 31));
    endfunction

    function automatic logic [7:0] pick_index();
        return used_index($urandom_range(0, USED_ENTRIES - 1));
    endfunction

    // Load the entries the stimulus reads, with the darkest and brightest colours at the ends.
    task automatic load_palette();
        logic [23:0] colour;
        for (int k = 0; k < USED_ENTRIES; k++) begin
            colour = (k == 0) ? 24'h000000 : (k == USED_ENTRIES - 1) ? 24'hFFFFFF
                   : 24'($urandom);
            send_beat(ACT_LOAD, 8'($urandom), used_index(k), colour, 1'($urandom));
        end
    endtask

    // One-pixel image from reset values, ignored beats, a zero run and a run cut at the line end.
    task automatic check_reset_setup();
        send_data(8'h00, 1'b0);
        send_data(8'hBF, 1'b1);
        send_beat(ACT_UNUSED, 8'hFF, 8'hFF, 24'hFFFFFF, 1'b1);
        start_image();
        send_data(8'hC0, 1'b0);
        send_data(8'hFF, 1'b0);
        send_data(8'hFF, 1'b1);
        start_image();
        send_data(8'hBF, 1'b1);
        start_image();
        send_data(8'hC3, 1'b0);
        send_data(8'h0E, 1'b1);
    endtask

    // Largest legal geometry, cut short by a final byte.
    task automatic check_extremes();
        set_geometry(MAX_DIMENSION, MAX_DIMENSION, 65535);
        start_image();
        send_run(6'd63, 8'hFF);
        send_run(6'd63, 8'hF3);
        send_data(8'h04, 1'b0);
        send_run(6'd1, 8'h01);
        send_data(8'hBA, 1'b1);
    endtask

    // Runs cut at the line end and padding columns that produce nothing.
    task automatic check_padding_cut();
        set_geometry(3, 2, 5);
        start_image();
        send_run(6'd8, 8'h02);
        send_run(6'd4, 8'hB4);
        send_data(8'h05, 1'b0);
        send_data(8'h06, 1'b1);
    endtask

    // Each way the geometry can be illegal, each followed by a byte that must be ignored.
    task automatic check_bad_geometry();
        int unsigned w_set [7] = '{0, 4097, 1, 1, 8191, 10, 4096};
        int unsigned h_set [7] = '{1, 1, 0, 4097, 8191, 3, 1};
        int unsigned b_set [7] = '{1, 4097, 1, 1, 65535, 9, 4095};
        for (int i = 0; i < 7; i++) begin
            set_geometry(w_set[i], h_set[i], b_set[i]);
            start_image();
            send_data(8'($urandom), 1'($urandom));
            send_data(8'($urandom), 1'($urandom));
        end
    endtask

    // Height lowered below the current line, then line length shortened behind the position.
    task automatic check_mid_image_change();
        set_geometry(4, 4, 4);
        start_image();
        repeat (8) send_data(rand_literal(), 1'b0);
        set_geometry(4, 1, 4);
        send_data(rand_literal(), 1'b0);
        set_geometry(4, 4, 8);
        start_image();
        repeat (6) send_data(rand_literal(), 1'b0);
        set_geometry(4, 4, 4);
        send_data(rand_literal(), 1'b0);
        send_data(rand_literal(), 1'b1);
    endtask

    // Mostly well-formed images of random geometry, with noise and broken streams mixed in.
    task automatic run_random_images(input int unsigned budget);
        int unsigned first, img, sel, w, h, bpl, beat_no, cnt;
        logic [7:0]  b;
        first = beats_sent;
        img   = 0;
        while (beats_sent - first < budget) begin
            idle_on = (img % 4 != 3);
            sel = $urandom_range(0, 99);
            if (sel < 8) begin
                w   = $urandom_range(64, 300);
                h   = 1;
                bpl = w + $urandom_range(0, 64);
            end else if (sel < 16) begin
                w   = $urandom_range(2, 40);
                h   = $urandom_range(1, 4);
                bpl = $urandom_range(1, w - 1);
            end else begin
                w   = $urandom_range(1, 12);
                h   = $urandom_range(1, 5);
                bpl = w + ($urandom_range(0, 1) ? $urandom_range(0, 4) : 0);
            end
            set_geometry(w, h, bpl);
            start_image();
            beat_no = 0;
            while (!img_closed && beats_sent - first < budget) begin
                beat_no++;
                if (img % 3 == 1 && beat_no == 6) drain();
                sel = $urandom_range(0, 99);
                if (sel < 3) begin
                    send_beat(ACT_UNUSED, 8'($urandom), 8'($urandom), 24'($urandom), 1'($urandom));
                end else if (sel < 6) begin
                    send_beat(ACT_LOAD, 8'($urandom), 8'($urandom), 24'($urandom), 1'($urandom));
                end else if (sel < 8) begin
                    start_image();
                end else begin
                    if (!run_armed && sel < 38) begin
                        cnt = $urandom_range(0, 99);
                        cnt = (cnt < 45) ? $urandom_range(0, 7)
                            : (cnt < 85) ? $urandom_range(8, 40) : $urandom_range(41, 63);
                        b = RUN_MARK | 8'(cnt);
                    end else begin
                        b = run_armed ? pick_index() : rand_literal();
                    end
                    send_data(b, 1'($urandom_range(0, 99) < 3));
                end
            end
            // Trailing bytes after the end of an image must be dropped.
            if (img_closed && $urandom_range(0, 99) < 30)
                send_data(8'($urandom), 1'($urandom));
            img++;
        end
        idle_on = 1'b1;
    endtask

    // Receiver back-pressure.
    always @(posedge aclk) begin
        if (stall_left == 0) stall_left = pick_gap(12);
        if (stall_left != 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic report_fault(input string what, input logic [31:0] got,
                                input logic [31:0] exp_val);
        if (fault_count < MAX_REPORTS)
            $display("[%0t] %s: got 0x%0h, expected 0x%0h", $time, what, got, exp_val);
        fault_count++;
    endtask

    // Compare every result beat with the oldest prediction.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (decoded_q.size() == 0) begin
                report_fault("result beat with nothing predicted, kind", m_kind, '0);
            end else begin
                want = decoded_q.pop_front();
                if (m_kind !== want.kind)     report_fault("kind", m_kind, want.kind);
                if (m_red !== want.red)       report_fault("red", m_red, want.red);
                if (m_green !== want.green)   report_fault("green", m_green, want.green);
                if (m_blue !== want.blue)     report_fault("blue", m_blue, want.blue);
                if (m_column !== want.column) report_fault("column", m_column, want.column);
                if (m_row !== want.row)       report_fault("row", m_row, want.row);
                if (m_last !== want.last)     report_fault("last", m_last, want.last);
            end
        end
    end

    // Ends the run if neither channel nor the register port moves for too long.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || psel) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Timed out after %0d quiet cycles with %0d results outstanding.",
                     quiet_cycles, decoded_q.size());
            $display("** pcx_rle_palette_decoder: FAILED **");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < PALETTE_DEPTH; i++) pal_shadow[i] = '0;
        clear_image();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        load_palette();
        check_reset_setup();
        check_extremes();
        check_padding_cut();
        check_bad_geometry();
        check_mid_image_change();
        run_random_images(160);

        drain();
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("Run covered %0d input beats over %0d images and %0d register writes;",
                 beats_sent, images_run, reg_writes);
        $display("%0d result beats were checked, %0d mismatches found.",
                 results_seen, fault_count);
        if (fault_count == 0) $display("** pcx_rle_palette_decoder: PASSED **");
        else $display("** pcx_rle_palette_decoder: FAILED **");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+sv
sv/pcx_pkg.sv
sv/pcx_pal.sv
sv/pcx_seq.sv
sv/pcx_outq.sv
sv/pcx_rle_palette_decoder.sv
dv/tb.sv
